/* sv/pn3d_pkg.sv */
package pn3d_pkg;

   localparam int ONE_Q16 = 65536;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [7:0]  cx;
      logic [7:0]  cy;
      logic [7:0]  cz;
      logic [15:0] rx;
      logic [15:0] ry;
      logic [15:0] rz;
   } point_type;

   function automatic logic [7:0] perm(input logic [7:0] idx);
      logic [7:0] r;
      case (idx)
         8'd0: r = 8'd182; 8'd1: r = 8'd232; 8'd2: r = 8'd51; 8'd3: r = 8'd15;
         8'd4: r = 8'd55; 8'd5: r = 8'd119; 8'd6: r = 8'd7; 8'd7: r = 8'd107;
         8'd8: r = 8'd230; 8'd9: r = 8'd227; 8'd10: r = 8'd6; 8'd11: r = 8'd34;
         8'd12: r = 8'd216; 8'd13: r = 8'd61; 8'd14: r = 8'd183; 8'd15: r = 8'd36;
         8'd16: r = 8'd40; 8'd17: r = 8'd134; 8'd18: r = 8'd74; 8'd19: r = 8'd45;
         8'd20: r = 8'd157; 8'd21: r = 8'd78; 8'd22: r = 8'd81; 8'd23: r = 8'd114;
         8'd24: r = 8'd145; 8'd25: r = 8'd9; 8'd26: r = 8'd209; 8'd27: r = 8'd189;
         8'd28: r = 8'd147; 8'd29: r = 8'd58; 8'd30: r = 8'd126; 8'd31: r = 8'd0;
         8'd32: r = 8'd240; 8'd33: r = 8'd169; 8'd34: r = 8'd228; 8'd35: r = 8'd235;
         8'd36: r = 8'd67; 8'd37: r = 8'd198; 8'd38: r = 8'd72; 8'd39: r = 8'd64;
         8'd40: r = 8'd88; 8'd41: r = 8'd98; 8'd42: r = 8'd129; 8'd43: r = 8'd194;
         8'd44: r = 8'd99; 8'd45: r = 8'd71; 8'd46: r = 8'd30; 8'd47: r = 8'd127;
         8'd48: r = 8'd18; 8'd49: r = 8'd150; 8'd50: r = 8'd155; 8'd51: r = 8'd179;
         8'd52: r = 8'd132; 8'd53: r = 8'd62; 8'd54: r = 8'd116; 8'd55: r = 8'd200;
         8'd56: r = 8'd251; 8'd57: r = 8'd178; 8'd58: r = 8'd32; 8'd59: r = 8'd140;
         8'd60: r = 8'd130; 8'd61: r = 8'd139; 8'd62: r = 8'd250; 8'd63: r = 8'd26;
         8'd64: r = 8'd151; 8'd65: r = 8'd203; 8'd66: r = 8'd106; 8'd67: r = 8'd123;
         8'd68: r = 8'd53; 8'd69: r = 8'd255; 8'd70: r = 8'd75; 8'd71: r = 8'd254;
         8'd72: r = 8'd86; 8'd73: r = 8'd234; 8'd74: r = 8'd223; 8'd75: r = 8'd19;
         8'd76: r = 8'd199; 8'd77: r = 8'd244; 8'd78: r = 8'd241; 8'd79: r = 8'd1;
         8'd80: r = 8'd172; 8'd81: r = 8'd70; 8'd82: r = 8'd24; 8'd83: r = 8'd97;
         8'd84: r = 8'd196; 8'd85: r = 8'd10; 8'd86: r = 8'd90; 8'd87: r = 8'd246;
         8'd88: r = 8'd252; 8'd89: r = 8'd68; 8'd90: r = 8'd84; 8'd91: r = 8'd161;
         8'd92: r = 8'd236; 8'd93: r = 8'd205; 8'd94: r = 8'd80; 8'd95: r = 8'd91;
         8'd96: r = 8'd233; 8'd97: r = 8'd225; 8'd98: r = 8'd164; 8'd99: r = 8'd217;
         8'd100: r = 8'd239; 8'd101: r = 8'd220; 8'd102: r = 8'd20; 8'd103: r = 8'd46;
         8'd104: r = 8'd204; 8'd105: r = 8'd35; 8'd106: r = 8'd31; 8'd107: r = 8'd175;
         8'd108: r = 8'd154; 8'd109: r = 8'd17; 8'd110: r = 8'd133; 8'd111: r = 8'd117;
         8'd112: r = 8'd73; 8'd113: r = 8'd224; 8'd114: r = 8'd125; 8'd115: r = 8'd65;
         8'd116: r = 8'd77; 8'd117: r = 8'd173; 8'd118: r = 8'd3; 8'd119: r = 8'd2;
         8'd120: r = 8'd242; 8'd121: r = 8'd221; 8'd122: r = 8'd120; 8'd123: r = 8'd218;
         8'd124: r = 8'd56; 8'd125: r = 8'd190; 8'd126: r = 8'd166; 8'd127: r = 8'd11;
         8'd128: r = 8'd138; 8'd129: r = 8'd208; 8'd130: r = 8'd231; 8'd131: r = 8'd50;
         8'd132: r = 8'd135; 8'd133: r = 8'd109; 8'd134: r = 8'd213; 8'd135: r = 8'd187;
         8'd136: r = 8'd152; 8'd137: r = 8'd201; 8'd138: r = 8'd47; 8'd139: r = 8'd168;
         8'd140: r = 8'd185; 8'd141: r = 8'd186; 8'd142: r = 8'd167; 8'd143: r = 8'd165;
         8'd144: r = 8'd102; 8'd145: r = 8'd153; 8'd146: r = 8'd156; 8'd147: r = 8'd49;
         8'd148: r = 8'd202; 8'd149: r = 8'd69; 8'd150: r = 8'd195; 8'd151: r = 8'd92;
         8'd152: r = 8'd21; 8'd153: r = 8'd229; 8'd154: r = 8'd63; 8'd155: r = 8'd104;
         8'd156: r = 8'd197; 8'd157: r = 8'd136; 8'd158: r = 8'd148; 8'd159: r = 8'd94;
         8'd160: r = 8'd171; 8'd161: r = 8'd93; 8'd162: r = 8'd59; 8'd163: r = 8'd149;
         8'd164: r = 8'd23; 8'd165: r = 8'd144; 8'd166: r = 8'd160; 8'd167: r = 8'd57;
         8'd168: r = 8'd76; 8'd169: r = 8'd141; 8'd170: r = 8'd96; 8'd171: r = 8'd158;
         8'd172: r = 8'd163; 8'd173: r = 8'd219; 8'd174: r = 8'd237; 8'd175: r = 8'd113;
         8'd176: r = 8'd206; 8'd177: r = 8'd181; 8'd178: r = 8'd112; 8'd179: r = 8'd111;
         8'd180: r = 8'd191; 8'd181: r = 8'd137; 8'd182: r = 8'd207; 8'd183: r = 8'd215;
         8'd184: r = 8'd13; 8'd185: r = 8'd83; 8'd186: r = 8'd238; 8'd187: r = 8'd249;
         8'd188: r = 8'd100; 8'd189: r = 8'd131; 8'd190: r = 8'd118; 8'd191: r = 8'd243;
         8'd192: r = 8'd162; 8'd193: r = 8'd248; 8'd194: r = 8'd43; 8'd195: r = 8'd66;
         8'd196: r = 8'd226; 8'd197: r = 8'd27; 8'd198: r = 8'd211; 8'd199: r = 8'd95;
         8'd200: r = 8'd214; 8'd201: r = 8'd105; 8'd202: r = 8'd108; 8'd203: r = 8'd101;
         8'd204: r = 8'd170; 8'd205: r = 8'd128; 8'd206: r = 8'd210; 8'd207: r = 8'd87;
         8'd208: r = 8'd38; 8'd209: r = 8'd44; 8'd210: r = 8'd174; 8'd211: r = 8'd188;
         8'd212: r = 8'd176; 8'd213: r = 8'd39; 8'd214: r = 8'd14; 8'd215: r = 8'd143;
         8'd216: r = 8'd159; 8'd217: r = 8'd16; 8'd218: r = 8'd124; 8'd219: r = 8'd222;
         8'd220: r = 8'd33; 8'd221: r = 8'd247; 8'd222: r = 8'd37; 8'd223: r = 8'd245;
         8'd224: r = 8'd8; 8'd225: r = 8'd4; 8'd226: r = 8'd22; 8'd227: r = 8'd82;
         8'd228: r = 8'd110; 8'd229: r = 8'd180; 8'd230: r = 8'd184; 8'd231: r = 8'd12;
         8'd232: r = 8'd25; 8'd233: r = 8'd5; 8'd234: r = 8'd193; 8'd235: r = 8'd41;
         8'd236: r = 8'd85; 8'd237: r = 8'd177; 8'd238: r = 8'd192; 8'd239: r = 8'd253;
         8'd240: r = 8'd79; 8'd241: r = 8'd29; 8'd242: r = 8'd115; 8'd243: r = 8'd103;
         8'd244: r = 8'd142; 8'd245: r = 8'd146; 8'd246: r = 8'd52; 8'd247: r = 8'd48;
         8'd248: r = 8'd89; 8'd249: r = 8'd54; 8'd250: r = 8'd121; 8'd251: r = 8'd212;
         8'd252: r = 8'd122; 8'd253: r = 8'd60; 8'd254: r = 8'd28; 8'd255: r = 8'd42;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // hash mod 12 through a small split: h = 12*q + r, q < 22
   function automatic logic [3:0] mod12(input logic [7:0] h);
      logic [8:0] t;
      t = {1'b0, h};
      if (t >= 9'd192) t = t - 9'd192;
      if (t >= 9'd96)  t = t - 9'd96;
      if (t >= 9'd48)  t = t - 9'd48;
      if (t >= 9'd24)  t = t - 9'd24;
      if (t >= 9'd12)  t = t - 9'd12;
      return t[3:0];
   endfunction

   // gradient dot product; ox, oy, oz are 18-bit signed offsets
   function automatic logic signed [18:0] grad_dot(input logic [3:0] g,
         input logic signed [17:0] ox, input logic signed [17:0] oy,
         input logic signed [17:0] oz);
      logic signed [18:0] a;
      logic signed [18:0] b;
      logic signed [18:0] c;
      a = 19'(ox);
      b = 19'(oy);
      c = 19'(oz);
      case (g)
         4'd0:  return a + b;
         4'd1:  return b - a;
         4'd2:  return a - b;
         4'd3:  return -a - b;
         4'd4:  return a + c;
         4'd5:  return c - a;
         4'd6:  return a - c;
         4'd7:  return -a - c;
         4'd8:  return b + c;
         4'd9:  return c - b;
         4'd10: return b - c;
         4'd11: return -b - c;
         default: return '0;
      endcase
   endfunction

endpackage

/* sv/perlin_noise_3d_top.sv */
// channel | ports                          | dir | item
// req     | req_valid req_stall req_coord_* | in  | point, Q(32-FRAC_BITS).FRAC_BITS
// rsp     | rsp_valid rsp_stall rsp_noise_value | out | noise, signed 2.16
//
// one item per cycle sustained while rsp_stall is low; the path is a front register, a
// two-entry queue and a nine-stage back pipeline set by the hash chain, fade and lerp multiplies
// reset clears only valid bits and the queue pointers and count
// a rsp stall with rsp_valid high freezes the back pipeline; the queue then fills and stalls req
module perlin_noise_3d_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_noise_value
);

   logic                f_valid;
   logic                f_stall;
   pn3d_pkg::point_type f_data;
   logic                q_valid;
   logic                q_stall;
   pn3d_pkg::point_type q_data;

   pn3d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .pt_valid(f_valid), .pt_stall(f_stall), .pt_data(f_data)
   );

   pn3d_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   pn3d_back u_back (
      .clock(clock), .reset(reset),
      .pt_valid(q_valid), .pt_stall(q_stall), .pt_data(q_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_noise_value(rsp_noise_value)
   );

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value <= 18'sd65536 && rsp_noise_value >= -18'sd65536))
      else $error("noise out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("result changed under stall");

   a_qfull: assert property (@(posedge clock) disable iff (reset)
      f_stall |-> q_valid)
      else $error("queue full but empty");

endmodule

/* sv/pn3d_front.sv */
module pn3d_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_coord_x,
   input  logic signed [31:0]       req_coord_y,
   input  logic signed [31:0]       req_coord_z,
   output logic                     pt_valid,
   input  logic                     pt_stall,
   output pn3d_pkg::point_type      pt_data
);

   logic                  full_ff;
   logic                  full_in;
   pn3d_pkg::point_type   data_ff;
   pn3d_pkg::point_type   data_in;

   function automatic logic [15:0] frac16(input logic [31:0] v);
      logic [FRAC_BITS-1:0] f;
      f = v[FRAC_BITS-1:0];
      if (FRAC_BITS >= 16)
         return 16'(f >> (FRAC_BITS - 16));
      else
         return 16'({f, 16'd0} >> FRAC_BITS);
   endfunction

   assign req_stall = full_ff && pt_stall;

   always_comb begin
      data_in.cx = req_coord_x[FRAC_BITS+7:FRAC_BITS];
      data_in.cy = req_coord_y[FRAC_BITS+7:FRAC_BITS];
      data_in.cz = req_coord_z[FRAC_BITS+7:FRAC_BITS];
      data_in.rx = frac16(req_coord_x);
      data_in.ry = frac16(req_coord_y);
      data_in.rz = frac16(req_coord_z);
      full_in = full_ff;
      if (!req_stall) begin
         full_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (!req_stall && req_valid) begin
         data_ff <= data_in;
      end
   end

   assign pt_valid = full_ff;
   assign pt_data  = data_ff;

endmodule

/* sv/pn3d_queue.sv */
module pn3d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  pn3d_pkg::point_type   in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output pn3d_pkg::point_type   out_data
);

   pn3d_pkg::point_type mem_ff [2];
   logic       wr_ff;
   logic       wr_in;
   logic       rd_ff;
   logic       rd_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;
   logic       pop;

   assign in_stall  = cnt_ff == 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

/* sv/pn3d_back.sv */
module pn3d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pt_valid,
   output logic                  pt_stall,
   input  pn3d_pkg::point_type   pt_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [17:0]    rsp_noise_value
);

   localparam int NS = 9;

   logic [NS-1:0] vld_ff;
   logic          adv;

   // stage 1: z level hashes, fade squares and inner partial
   pn3d_pkg::point_type p1_ff;
   logic [7:0]  hz1_ff [2];
   logic [31:0] sq_ff [3];
   logic signed [37:0] in1_ff [3];
   // stage 2: y level hashes, fade inner and t3 partial
   pn3d_pkg::point_type p2_ff;
   logic [7:0]  hy2_ff [4];
   logic [16:0] tt_ff [3];
   logic signed [20:0] inn_ff [3];
   // stage 3: final hashes, t3
   pn3d_pkg::point_type p3_ff;
   logic [7:0]  h3_ff [8];
   logic [16:0] t3_ff [3];
   logic signed [20:0] inn3_ff [3];
   // stage 4: dot products, fade
   logic signed [18:0] n_ff [8];
   logic [16:0] fd_ff [3];
   // stage 5/6: x lerp
   logic signed [36:0] px_ff [4];
   logic signed [18:0] ax_ff [4];
   logic [16:0] fd5_ff [2];
   logic signed [19:0] nx_ff [4];
   logic [16:0] fd6_ff [2];
   // stage 7/8: y lerp
   logic signed [37:0] py_ff [2];
   logic signed [19:0] ay_ff [2];
   logic [16:0] fd7_ff;
   logic signed [20:0] ny_ff [2];
   logic [16:0] fd8_ff;
   // stage 9: z lerp and clamp
   logic signed [17:0] res_ff;

   logic signed [17:0] ox [8];
   logic signed [17:0] oy [8];
   logic signed [17:0] oz [8];
   logic [15:0] tv [3];
   logic signed [19:0] dx_w [4];
   logic signed [20:0] dy_w [2];
   logic signed [21:0] dz_w;
   logic signed [38:0] pz_w;
   logic signed [22:0] r_w;

   assign adv       = !(vld_ff[NS-1] && rsp_stall);
   assign pt_stall  = !adv;
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_noise_value = res_ff;

   always_comb begin
      tv[0] = p3_ff.rx;
      tv[1] = p3_ff.ry;
      tv[2] = p3_ff.rz;
      for (int i = 0; i < 8; i++) begin
         ox[i] = i[2] ? $signed({2'b0, tv[0]}) - 18'sd65536 : $signed({2'b0, tv[0]});
         oy[i] = i[1] ? $signed({2'b0, tv[1]}) - 18'sd65536 : $signed({2'b0, tv[1]});
         oz[i] = i[0] ? $signed({2'b0, tv[2]}) - 18'sd65536 : $signed({2'b0, tv[2]});
      end
      for (int i = 0; i < 4; i++) begin
         dx_w[i] = 20'(n_ff[4+i]) - 20'(n_ff[i]);
      end
      for (int i = 0; i < 2; i++) begin
         dy_w[i] = 21'(nx_ff[2+i]) - 21'(nx_ff[i]);
      end
      dz_w = 22'(ny_ff[1]) - 22'(ny_ff[0]);
      pz_w = 39'(dz_w * $signed({1'b0, fd8_ff}));
      r_w  = 23'(ny_ff[0]) + 23'(pz_w >>> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], pt_valid};
      end
      if (adv) begin
         p1_ff <= pt_data;
         hz1_ff[0] <= pn3d_pkg::perm(pt_data.cz);
         hz1_ff[1] <= pn3d_pkg::perm(pt_data.cz + 8'd1);
         sq_ff[0] <= pt_data.rx * pt_data.rx;
         sq_ff[1] <= pt_data.ry * pt_data.ry;
         sq_ff[2] <= pt_data.rz * pt_data.rz;
         in1_ff[0] <= $signed({22'd0, pt_data.rx})
                      * ($signed({22'd0, pt_data.rx}) * 38'sd6 - 38'sd983040);
         in1_ff[1] <= $signed({22'd0, pt_data.ry})
                      * ($signed({22'd0, pt_data.ry}) * 38'sd6 - 38'sd983040);
         in1_ff[2] <= $signed({22'd0, pt_data.rz})
                      * ($signed({22'd0, pt_data.rz}) * 38'sd6 - 38'sd983040);

         p2_ff <= p1_ff;
         for (int j = 0; j < 4; j++) begin
            hy2_ff[j] <= pn3d_pkg::perm(p1_ff.cy + 8'(j >> 1) + hz1_ff[j & 1]);
         end
         for (int k = 0; k < 3; k++) begin
            tt_ff[k]  <= 17'(sq_ff[k] >> 16);
            inn_ff[k] <= 21'(in1_ff[k] >>> 16) + 21'sd655360;
         end

         p3_ff <= p2_ff;
         for (int j = 0; j < 8; j++) begin
            h3_ff[j] <= pn3d_pkg::perm(p2_ff.cx + 8'(j >> 2) + hy2_ff[j & 3]);
         end
         t3_ff[0] <= 17'((34'(tt_ff[0]) * 34'(p2_ff.rx)) >> 16);
         t3_ff[1] <= 17'((34'(tt_ff[1]) * 34'(p2_ff.ry)) >> 16);
         t3_ff[2] <= 17'((34'(tt_ff[2]) * 34'(p2_ff.rz)) >> 16);
         inn3_ff <= inn_ff;

         for (int j = 0; j < 8; j++) begin
            n_ff[j] <= pn3d_pkg::grad_dot(pn3d_pkg::mod12(h3_ff[j]), ox[j], oy[j], oz[j]);
         end
         for (int k = 0; k < 3; k++) begin
            logic signed [37:0] fm;
            fm = (38'($signed({1'b0, t3_ff[k]})) * 38'(inn3_ff[k])) >>> 16;
            if (fm > 38'sd65536)
               fd_ff[k] <= 17'd65536;
            else if (fm < 38'sd0)
               fd_ff[k] <= 17'd0;
            else
               fd_ff[k] <= fm[16:0];
         end

         for (int j = 0; j < 4; j++) begin
            px_ff[j] <= 37'(dx_w[j] * $signed({1'b0, fd_ff[0]}));
            ax_ff[j] <= n_ff[j];
         end
         fd5_ff[0] <= fd_ff[1];
         fd5_ff[1] <= fd_ff[2];

         for (int j = 0; j < 4; j++) begin
            nx_ff[j] <= 20'(ax_ff[j]) + 20'(px_ff[j] >>> 16);
         end
         fd6_ff <= fd5_ff;

         for (int j = 0; j < 2; j++) begin
            py_ff[j] <= 38'(dy_w[j] * $signed({1'b0, fd6_ff[0]}));
            ay_ff[j] <= nx_ff[j];
         end
         fd7_ff <= fd6_ff[1];

         for (int j = 0; j < 2; j++) begin
            ny_ff[j] <= 21'(ay_ff[j]) + 21'(py_ff[j] >>> 16);
         end
         fd8_ff <= fd7_ff;

         if (r_w > 23'sd65536)
            res_ff <= 18'sd65536;
         else if (r_w < -23'sd65536)
            res_ff <= -18'sd65536;
         else
            res_ff <= r_w[17:0];
      end
   end

endmodule
